[design/indexed_set_with_undo_assert.svh]
// Assertion macros for the indexed set block
`ifndef INDEXED_SET_WITH_UNDO_ASSERT_SVH
`define INDEXED_SET_WITH_UNDO_ASSERT_SVH
`ifndef SYNTHESIS
`define ISU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ISU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ISU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ISU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/isu_pkg.sv]
package isu_pkg;
	typedef enum logic [2:0] {
		CMD_INIT    = 3'd0,
		CMD_ADD     = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_RESTORE = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_INS_RD,
		ST_INS_WR,
		ST_DEL_RD,
		ST_DEL_RD2,
		ST_DEL_CHK,
		ST_DEL_WR,
		ST_DEL_WR2,
		ST_LOG_A_RD,
		ST_LOG_A_GO,
		ST_LOG_R_RD,
		ST_LOG_R_GO,
		ST_RD_RD,
		ST_RD_GO,
		ST_DONE
	} state_t;

	localparam int unsigned LIST_DEPTH = 256;
	localparam int unsigned LIST_AW = 8;
	localparam int unsigned SLOT_W = 9;
	localparam logic [8:0] ABSENT = 9'd256;
endpackage

[design/isu_ram.sv]
module isu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/indexed_set_with_undo.sv]
// Sparse set of board cells with an undo log. One item at a time; stall is
// high while an item is at work, and the next item is taken in the cycle
// after the result leaves. From the accepting edge to the result: read runs
// through RD_RD, RD_GO; add through INS_RD, INS_WR; remove through DEL_RD,
// DEL_RD2, DEL_CHK, as the position map and the list are single-port-read
// RAMs read in turn, then DEL_WR, DEL_WR2 unless the cell is absent.
// Init sweeps the map, one cell a cycle, over BOARD_SIDE*BOARD_SIDE cells,
// then inserts its cell. Restore removes logged adds, adds logged removes.
// After reset the same map sweep runs once before the first item is taken.
module indexed_set_with_undo #(
	parameter int BOARD_SIDE = 16,
	parameter int LOG_DEPTH  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [3:0] cell_rank,
	input  logic [3:0] cell_file,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       changed,
	output logic [8:0] member_count,
	output logic [3:0] rank_out,
	output logic [3:0] file_out,
	output logic       log_overflow
);
	`include "indexed_set_with_undo_assert.svh"

	localparam int MAP_CELLS = BOARD_SIDE * BOARD_SIDE;
	localparam int MAP_AW = $clog2(MAP_CELLS);
	localparam int LOG_AW = $clog2(LOG_DEPTH);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	isu_pkg::state_t state_q, state_d;

	logic [8:0] size_q;
	logic [CNT_W-1:0] acount_q, rcount_q, logi_q;
	logic [MAP_AW-1:0] clr_q;
	logic [2:0] cmd_q;
	logic [7:0] cell_q, last_q, idx_q;
	logic [8:0] pos_q;
	logic chg_q, ovf_q, ok_q;

	logic map_we;
	logic [MAP_AW-1:0] map_wa, map_ra;
	logic [8:0] map_wd, map_rd;
	logic lst_we;
	logic [7:0] lst_wa, lst_ra, lst_wd, lst_rd;
	logic alog_we, rlog_we;
	logic [LOG_AW-1:0] log_wa, log_ra;
	logic [7:0] alog_rd, rlog_rd;

	function automatic logic [MAP_AW-1:0] midx(input logic [7:0] p);
		logic [MAP_AW+4:0] v;
		v = (MAP_AW+5)'(p[7:4]) * (MAP_AW+5)'(BOARD_SIDE) + (MAP_AW+5)'(p[3:0]);
		return v[MAP_AW-1:0];
	endfunction

	function automatic logic onb(input logic [7:0] p);
		return (32'(p[7:4]) < BOARD_SIDE) && (32'(p[3:0]) < BOARD_SIDE);
	endfunction

	isu_ram #(.WIDTH(9), .DEPTH(MAP_CELLS)) u_map (
		.clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
		.raddr(map_ra), .rdata(map_rd));
	isu_ram #(.WIDTH(8), .DEPTH(isu_pkg::LIST_DEPTH)) u_list (
		.clk(clk), .we(lst_we), .waddr(lst_wa), .wdata(lst_wd),
		.raddr(lst_ra), .rdata(lst_rd));
	isu_ram #(.WIDTH(8), .DEPTH(LOG_DEPTH)) u_alog (
		.clk(clk), .we(alog_we), .waddr(log_wa), .wdata(cell_q),
		.raddr(log_ra), .rdata(alog_rd));
	isu_ram #(.WIDTH(8), .DEPTH(LOG_DEPTH)) u_rlog (
		.clk(clk), .we(rlog_we), .waddr(log_wa), .wdata(cell_q),
		.raddr(log_ra), .rdata(rlog_rd));

	logic accept, deliver, ins_ok, del_ok, is_restore;
	assign accept = in_valid && !in_stall;
	assign deliver = out_valid && !out_stall;
	assign is_restore = (cmd_q == isu_pkg::CMD_RESTORE);
	assign ins_ok = (map_rd == isu_pkg::ABSENT) && (size_q != 9'd256);
	assign del_ok = (size_q != 9'd0) && (pos_q < size_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			isu_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						isu_pkg::CMD_INIT:    state_d = isu_pkg::ST_CLR;
						isu_pkg::CMD_ADD:     state_d = onb({cell_rank, cell_file}) ?
							isu_pkg::ST_INS_RD : isu_pkg::ST_DONE;
						isu_pkg::CMD_REMOVE:  state_d = onb({cell_rank, cell_file}) ?
							isu_pkg::ST_DEL_RD : isu_pkg::ST_DONE;
						isu_pkg::CMD_RESTORE: state_d = isu_pkg::ST_LOG_A_RD;
						isu_pkg::CMD_READ:    state_d = isu_pkg::ST_RD_RD;
						default:              state_d = isu_pkg::ST_DONE;
					endcase
				end
			end
			isu_pkg::ST_CLR: begin
				if (32'(clr_q) == MAP_CELLS - 1) begin
					if (!ok_q) begin
						state_d = isu_pkg::ST_IDLE;
					end else begin
						state_d = onb(cell_q) ? isu_pkg::ST_INS_RD : isu_pkg::ST_DONE;
					end
				end
			end
			isu_pkg::ST_INS_RD:  state_d = isu_pkg::ST_INS_WR;
			isu_pkg::ST_INS_WR:  state_d = is_restore ? isu_pkg::ST_LOG_R_RD : isu_pkg::ST_DONE;
			isu_pkg::ST_DEL_RD:  state_d = isu_pkg::ST_DEL_RD2;
			isu_pkg::ST_DEL_RD2: state_d = isu_pkg::ST_DEL_CHK;
			isu_pkg::ST_DEL_CHK: begin
				if (del_ok) begin
					state_d = isu_pkg::ST_DEL_WR;
				end else begin
					state_d = is_restore ? isu_pkg::ST_LOG_A_RD : isu_pkg::ST_DONE;
				end
			end
			isu_pkg::ST_DEL_WR:  state_d = isu_pkg::ST_DEL_WR2;
			isu_pkg::ST_DEL_WR2: state_d = is_restore ? isu_pkg::ST_LOG_A_RD : isu_pkg::ST_DONE;
			isu_pkg::ST_LOG_A_RD: begin
				state_d = (logi_q < acount_q) ? isu_pkg::ST_LOG_A_GO : isu_pkg::ST_LOG_R_RD;
			end
			isu_pkg::ST_LOG_A_GO: state_d = isu_pkg::ST_DEL_RD;
			isu_pkg::ST_LOG_R_RD: begin
				state_d = (logi_q < rcount_q) ? isu_pkg::ST_LOG_R_GO : isu_pkg::ST_DONE;
			end
			isu_pkg::ST_LOG_R_GO: state_d = isu_pkg::ST_INS_RD;
			isu_pkg::ST_RD_RD:    state_d = isu_pkg::ST_RD_GO;
			isu_pkg::ST_RD_GO:    state_d = isu_pkg::ST_DONE;
			isu_pkg::ST_DONE:     state_d = deliver ? isu_pkg::ST_IDLE : isu_pkg::ST_DONE;
			default:              state_d = isu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != isu_pkg::ST_IDLE);
		out_valid = (state_q == isu_pkg::ST_DONE);
		map_we = 1'b0;
		map_wa = midx(cell_q);
		map_wd = isu_pkg::ABSENT;
		map_ra = midx(cell_q);
		lst_we = 1'b0;
		lst_wa = size_q[7:0];
		lst_wd = cell_q;
		lst_ra = idx_q;
		alog_we = 1'b0;
		rlog_we = 1'b0;
		log_wa = (cmd_q == isu_pkg::CMD_ADD) ? acount_q[LOG_AW-1:0] : rcount_q[LOG_AW-1:0];
		log_ra = logi_q[LOG_AW-1:0];
		case (state_q)
			isu_pkg::ST_CLR: begin
				map_we = 1'b1;
				map_wa = clr_q;
			end
			isu_pkg::ST_INS_WR: begin
				if (ins_ok) begin
					map_we = 1'b1;
					map_wd = size_q;
					lst_we = 1'b1;
					if (cmd_q == isu_pkg::CMD_ADD && 32'(acount_q) < LOG_DEPTH) begin
						alog_we = 1'b1;
					end
				end
			end
			isu_pkg::ST_DEL_RD2: begin
				lst_ra = 8'(size_q - 9'd1);
			end
			isu_pkg::ST_DEL_WR: begin
				map_we = onb(last_q);
				map_wa = midx(last_q);
				map_wd = pos_q;
				lst_we = 1'b1;
				lst_wa = pos_q[7:0];
				lst_wd = last_q;
			end
			isu_pkg::ST_DEL_WR2: begin
				map_we = 1'b1;
				if (cmd_q == isu_pkg::CMD_REMOVE && 32'(rcount_q) < LOG_DEPTH) begin
					rlog_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isu_pkg::ST_CLR;
			size_q <= '0;
			acount_q <= '0;
			rcount_q <= '0;
			clr_q <= '0;
			logi_q <= '0;
			cmd_q <= isu_pkg::CMD_READ;
			cell_q <= '0;
			idx_q <= '0;
			last_q <= '0;
			pos_q <= '0;
			rank_out <= '0;
			file_out <= '0;
			ok_q <= 1'b0;
			chg_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				isu_pkg::ST_IDLE: begin
					if (accept) begin
						cmd_q <= command;
						cell_q <= {cell_rank, cell_file};
						idx_q <= read_index;
						ok_q <= 1'b1;
						chg_q <= 1'b0;
						ovf_q <= 1'b0;
						logi_q <= '0;
						rank_out <= '0;
						file_out <= '0;
						clr_q <= '0;
						if (command == isu_pkg::CMD_INIT) begin
							size_q <= '0;
							acount_q <= '0;
							rcount_q <= '0;
						end
					end
				end
				isu_pkg::ST_CLR: begin
					clr_q <= clr_q + 1'b1;
				end
				isu_pkg::ST_INS_WR: begin
					if (ins_ok) begin
						size_q <= size_q + 9'd1;
						if (cmd_q == isu_pkg::CMD_ADD) begin
							chg_q <= 1'b1;
							if (32'(acount_q) < LOG_DEPTH) begin
								acount_q <= acount_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				isu_pkg::ST_DEL_RD2: begin
					pos_q <= map_rd;
				end
				isu_pkg::ST_DEL_CHK: begin
					last_q <= lst_rd;
				end
				isu_pkg::ST_DEL_WR2: begin
					size_q <= size_q - 9'd1;
					if (cmd_q == isu_pkg::CMD_REMOVE) begin
						chg_q <= 1'b1;
						if (32'(rcount_q) < LOG_DEPTH) begin
							rcount_q <= rcount_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				isu_pkg::ST_LOG_A_RD: begin
					if (!(logi_q < acount_q)) begin
						logi_q <= '0;
					end
				end
				isu_pkg::ST_LOG_A_GO: begin
					cell_q <= alog_rd;
					logi_q <= logi_q + 1'b1;
				end
				isu_pkg::ST_LOG_R_RD: begin
					if (!(logi_q < rcount_q)) begin
						acount_q <= '0;
						rcount_q <= '0;
					end
				end
				isu_pkg::ST_LOG_R_GO: begin
					cell_q <= rlog_rd;
					logi_q <= logi_q + 1'b1;
				end
				isu_pkg::ST_RD_GO: begin
					if ({1'b0, idx_q} < size_q) begin
						rank_out <= lst_rd[7:4];
						file_out <= lst_rd[3:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign changed = chg_q;
	assign log_overflow = ovf_q;
	assign member_count = size_q;

	`ISU_ASSERT_IMPL(a_size_range, clk, arst_n, 1'b1, size_q <= 9'd256)
	`ISU_ASSERT_IMPL(a_ovf_needs_chg, clk, arst_n, out_valid && log_overflow, changed)
	`ISU_ASSERT_NEXT(a_log_cnt, clk, arst_n, 1'b1,
		(32'(acount_q) <= LOG_DEPTH) && (32'(rcount_q) <= LOG_DEPTH))
	`ISU_ASSERT_IMPL(a_busy_stall, clk, arst_n, out_valid, in_stall)
endmodule

[test/testbench.sv]
module testbench;
	localparam int BOARD = 16;
	localparam int LOGD  = 64;
	localparam int NRAND = 1000;
	localparam logic [8:0] NO_SLOT = 9'd256;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] command = 3'd0;
	logic [3:0] cell_rank = 4'd0;
	logic [3:0] cell_file = 4'd0;
	logic [7:0] read_index = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       changed;
	logic [8:0] member_count;
	logic [3:0] rank_out;
	logic [3:0] file_out;
	logic       log_overflow;

	indexed_set_with_undo #(.BOARD_SIDE(BOARD), .LOG_DEPTH(LOGD)) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic       chg;
		logic [8:0] count;
		logic [3:0] rank;
		logic [3:0] file;
		logic       ovf;
	} answer_t;

	typedef struct {
		logic [2:0] cmd;
		logic [3:0] rank;
		logic [3:0] file;
		logic [7:0] idx;
		bit         typed;
		answer_t    ans;
	} row_t;

	// set state mirror
	logic [8:0] slot_of[256];
	logic [7:0] members[256];
	int         size_now;
	logic [7:0] adds_log[LOGD];
	logic [7:0] rems_log[LOGD];
	int         n_adds, n_rems;

	answer_t    pending[$];
	int         errors = 0;
	int         n_results = 0;
	int         n_overflow = 0;
	int         n_restore = 0;
	bit         hold_off = 1'b0;
	bit         calm_out = 1'b0;

	function automatic bit put_cell(logic [7:0] c);
		if (slot_of[c] != NO_SLOT || size_now >= 256) return 1'b0;
		slot_of[c] = size_now[8:0];
		members[size_now] = c;
		size_now++;
		return 1'b1;
	endfunction

	function automatic bit take_cell(logic [7:0] c);
		logic [8:0] pos;
		logic [7:0] last;
		pos = slot_of[c];
		if (size_now == 0 || pos >= size_now) return 1'b0;
		last = members[size_now - 1];
		slot_of[last] = pos;
		members[pos[7:0]] = last;
		slot_of[c] = NO_SLOT;
		size_now--;
		return 1'b1;
	endfunction

	function automatic answer_t set_step(logic [2:0] cmd, logic [3:0] r, logic [3:0] f,
			logic [7:0] idx);
		answer_t a;
		logic [7:0] c;
		bit d;
		a = '0;
		c = {r, f};
		case (cmd)
			isu_pkg::CMD_INIT: begin
				for (int i = 0; i < 256; i++) slot_of[i] = NO_SLOT;
				size_now = 0;
				n_adds = 0;
				n_rems = 0;
				d = put_cell(c);
			end
			isu_pkg::CMD_ADD: begin
				if (put_cell(c)) begin
					a.chg = 1'b1;
					if (n_adds < LOGD) adds_log[n_adds++] = c;
					else a.ovf = 1'b1;
				end
			end
			isu_pkg::CMD_REMOVE: begin
				if (take_cell(c)) begin
					a.chg = 1'b1;
					if (n_rems < LOGD) rems_log[n_rems++] = c;
					else a.ovf = 1'b1;
				end
			end
			isu_pkg::CMD_RESTORE: begin
				for (int i = 0; i < n_adds; i++) d = take_cell(adds_log[i]);
				for (int i = 0; i < n_rems; i++) d = put_cell(rems_log[i]);
				n_adds = 0;
				n_rems = 0;
			end
			isu_pkg::CMD_READ: begin
				if (idx < size_now) {a.rank, a.file} = members[idx];
			end
			default: ;
		endcase
		a.count = size_now[8:0];
		return a;
	endfunction

	task automatic offer(logic [2:0] cmd, logic [3:0] r, logic [3:0] f, logic [7:0] idx,
			bit typed = 1'b0, answer_t want = '0);
		answer_t got;
		while (!hold_off && !calm_out && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		cell_rank <= r;
		cell_file <= f;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = set_step(cmd, r, f, idx);
		if (typed && got != want) begin
			$display("%0t table row mismatch: expected %h actual %h", $time, want, got);
			errors++;
		end
		pending.push_back(got);
		if (cmd == isu_pkg::CMD_RESTORE) n_restore++;
	endtask

	// result side
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time,
					{changed, member_count, rank_out, file_out, log_overflow});
				errors++;
			end else begin
				answer_t e;
				e = pending.pop_front();
				if (log_overflow) n_overflow++;
				if (e.chg != changed) begin
					$display("%0t changed: expected %0d actual %0d", $time, e.chg, changed);
					errors++;
				end
				if (e.count != member_count) begin
					$display("%0t member_count: expected %0d actual %0d", $time, e.count,
						member_count);
					errors++;
				end
				if (e.rank != rank_out) begin
					$display("%0t rank_out: expected %0d actual %0d", $time, e.rank, rank_out);
					errors++;
				end
				if (e.file != file_out) begin
					$display("%0t file_out: expected %0d actual %0d", $time, e.file, file_out);
					errors++;
				end
				if (e.ovf != log_overflow) begin
					$display("%0t log_overflow: expected %0d actual %0d", $time, e.ovf,
						log_overflow);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (calm_out) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < 13);
	end

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
	endtask

	row_t rows[$];

	function automatic row_t mk(logic [2:0] c, logic [3:0] r, logic [3:0] f, logic [7:0] i,
			bit t = 1'b0, answer_t a = '0);
		row_t x;
		x.cmd = c; x.rank = r; x.file = f; x.idx = i; x.typed = t; x.ans = a;
		return x;
	endfunction

	initial begin
		int mode;
		logic [2:0] c;
		for (int i = 0; i < 256; i++) slot_of[i] = NO_SLOT;
		size_now = 0;
		n_adds = 0;
		n_rems = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd0, 1, '{0, 0, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_REMOVE, 4'd3, 4'd3, 0, 1, '{0, 0, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_INIT, 4'd15, 4'd15, 8'd255, 1, '{0, 1, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd0, 1, '{0, 1, 15, 15, 0}));
		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd255, 1, '{0, 1, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_ADD, 4'd0, 4'd0, 0, 1, '{1, 2, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_ADD, 4'd0, 4'd0, 0, 1, '{0, 2, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_ADD, 4'd5, 4'd10, 0));
		rows.push_back(mk(isu_pkg::CMD_REMOVE, 4'd15, 4'd15, 0));
		rows.push_back(mk(isu_pkg::CMD_REMOVE, 4'd15, 4'd15, 0, 1, '{0, 2, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd0));
		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd1));
		rows.push_back(mk(3'd5, 4'd1, 4'd1, 8'd1, 1, '{0, 2, 0, 0, 0}));
		rows.push_back(mk(3'd6, 4'd1, 4'd1, 8'd1, 1, '{0, 2, 0, 0, 0}));
		rows.push_back(mk(3'd7, 4'd1, 4'd1, 8'd1, 1, '{0, 2, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_ADD, 4'd15, 4'd15, 0));
		rows.push_back(mk(isu_pkg::CMD_RESTORE, 0, 0, 0, 1, '{0, 1, 0, 0, 0}));
		rows.push_back(mk(isu_pkg::CMD_READ, 0, 0, 8'd0, 1, '{0, 1, 15, 15, 0}));
		rows.push_back(mk(isu_pkg::CMD_INIT, 4'd0, 4'd0, 8'd0, 1, '{0, 1, 0, 0, 0}));
		foreach (rows[k]) offer(rows[k].cmd, rows[k].rank, rows[k].file, rows[k].idx,
			rows[k].typed, rows[k].ans);

		// fill all 256 cells, overflowing the add log, then empty it again
		for (int i = 1; i < 256; i++) offer(isu_pkg::CMD_ADD, i[7:4], i[3:0], 0);
		offer(isu_pkg::CMD_READ, 0, 0, 8'd255);
		for (int i = 0; i < 256; i++) offer(isu_pkg::CMD_REMOVE, i[7:4], i[3:0], 0);
		offer(isu_pkg::CMD_RESTORE, 0, 0, 0);
		drain();

		// receiver holds off while items keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 6; i++) offer(isu_pkg::CMD_READ, 0, 0, i[7:0]);
		join
		drain();

		for (int n = 0; n < NRAND; n++) begin
			calm_out = (n >= 600 && n < 800);
			mode = $urandom_range(99);
			if (mode < 2) c = isu_pkg::CMD_INIT;
			else if (mode < 40) c = isu_pkg::CMD_ADD;
			else if (mode < 65) c = isu_pkg::CMD_REMOVE;
			else if (mode < 70) c = isu_pkg::CMD_RESTORE;
			else if (mode < 97) c = isu_pkg::CMD_READ;
			else c = 3'($urandom_range(7, 5));
			if (n % 300 == 150) drain();
			offer(c, 4'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3)),
				4'($urandom_range(15)),
				8'((mode < 85) ? $urandom_range(15) : $urandom_range(255)));
		end
		drain();
		repeat (50) @(posedge clk);
		$display("Ran %0d results, %0d restores, %0d log overflows, with stalls and gaps.",
			n_results, n_restore, n_overflow);
		if (errors == 0 && pending.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#100000000;
		$display("Verification failed");
		$finish;
	end
endmodule
